// ----- rtl/isc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

  // Sizes
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned DATA_W      = 32;

  // Operation kinds
  localparam logic [2:0] KIND_PUSH = 3'd0;
  localparam logic [2:0] KIND_POP  = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_SUB  = 3'd3;
  localparam logic [2:0] KIND_MULT = 3'd4;
  localparam logic [2:0] KIND_QUOT = 3'd5;
  localparam logic [2:0] KIND_SUM  = 3'd6;
  localparam logic [2:0] KIND_PROD = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  // Command word
  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [3:0]               occupancy;
  } res_t;

  // Sequencer to arithmetic unit
  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  // Arithmetic unit back to sequencer
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/isc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/isc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isc_alu (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire isc_pkg::alu_req_t req_i,
  output isc_pkg::alu_rsp_t      rsp_o
);

  localparam int unsigned W = isc_pkg::DATA_W;
  localparam logic [4:0] LastStep = 5'(W - 1);

  logic              run_q, run_d;
  isc_pkg::alu_op_e  op_q, op_d;
  logic [4:0]        step_q, step_d;
  logic [W-1:0]      acc_q, acc_d;   // product or remainder
  logic [W-1:0]      x_q, x_d;       // multiplier or dividend/quotient
  logic [W-1:0]      y_q, y_d;       // multiplicand or divisor
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [W-1:0]      res_q, res_d;

  logic [W-1:0] a_mag, b_mag, mul_sum, rem_sh, quo;
  logic [W:0]   diff;

  // One shift-add or one restoring-divide step per cycle
  always_comb begin
    a_mag   = req_i.a[W-1] ? (W'(0) - req_i.a) : req_i.a;
    b_mag   = req_i.b[W-1] ? (W'(0) - req_i.b) : req_i.b;
    mul_sum = acc_q + (x_q[0] ? y_q : W'(0));
    rem_sh  = {acc_q[W-2:0], x_q[W-1]};
    diff    = {1'b0, rem_sh} - {1'b0, y_q};
    quo     = {x_q[W-2:0], ~diff[W]};

    run_d  = run_q;
    op_d   = op_q;
    step_d = step_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;

    if (run_q) begin
      unique case (op_q)
        isc_pkg::ALU_MUL: begin
          acc_d = mul_sum;
          x_d   = x_q >> 1;
          y_d   = y_q << 1;
        end
        isc_pkg::ALU_DIV: begin
          acc_d = diff[W] ? rem_sh : diff[W-1:0];
          x_d   = quo;
        end
        default: ;
      endcase
      step_d = step_q - 5'd1;
      if (step_q == 5'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        if (op_q == isc_pkg::ALU_MUL) begin
          res_d = mul_sum;
        end else begin
          res_d = neg_q ? (W'(0) - quo) : quo;
        end
      end
    end else if (req_i.start) begin
      op_d = req_i.op;
      unique case (req_i.op)
        isc_pkg::ALU_ADD: begin
          res_d  = req_i.a + req_i.b;
          done_d = 1'b1;
        end
        isc_pkg::ALU_SUB: begin
          res_d  = req_i.a - req_i.b;
          done_d = 1'b1;
        end
        isc_pkg::ALU_MUL: begin
          acc_d  = W'(0);
          x_d    = req_i.a;
          y_d    = req_i.b;
          step_d = LastStep;
          run_d  = 1'b1;
        end
        isc_pkg::ALU_DIV: begin
          acc_d  = W'(0);
          x_d    = a_mag;
          y_d    = b_mag;
          neg_d  = req_i.a[W-1] ^ req_i.b[W-1];
          step_d = LastStep;
          run_d  = 1'b1;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      op_q   <= isc_pkg::ALU_ADD;
      step_q <= 5'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      op_q   <= op_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

// ----- rtl/integer_stack_calculator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each accepted command runs through the sequencer states to a result strobe; mult/quot
// run one bit per cycle in the shared unit, and sum-all and product-all fold each entry
// through it in turn. Divide by zero and too few operands end without the unit.
// One command at a time: busy drops in the strobe cycle, so no new command is taken
// while one is in flight. The word is shown on res_o with done_o, a one-cycle strobe; no stall.
// Reset (async, active low) empties the stack; the stack RAM itself is not cleared.
module integer_stack_calculator_top #(
  parameter int unsigned StackDepth = isc_pkg::STACK_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire isc_pkg::cmd_t cmd_i,
  output logic               done_o,
  output isc_pkg::res_t      res_o
);

  localparam int unsigned W  = isc_pkg::DATA_W;
  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned CW = $clog2(StackDepth + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_POP_WAIT  = 4'd2;
  localparam logic [3:0] S_RD_S      = 4'd3;
  localparam logic [3:0] S_OPERANDS  = 4'd4;
  localparam logic [3:0] S_BIN_WAIT  = 4'd5;
  localparam logic [3:0] S_FOLD_RD   = 4'd6;
  localparam logic [3:0] S_FOLD_OP   = 4'd7;
  localparam logic [3:0] S_FOLD_WAIT = 4'd8;
  localparam logic [3:0] S_FIN       = 4'd9;
  localparam logic [3:0] S_FIN_WAIT  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [2:0]    kind_q, kind_d;
  logic [W-1:0]  value_q, value_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  top_q, top_d;
  logic [1:0]    status_q, status_d;
  logic          done_q, done_d;
  isc_pkg::res_t res_q, res_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;
  logic [CW-1:0] cnt_m1, cnt_m2;

  isc_pkg::alu_req_t alu_req;
  isc_pkg::alu_rsp_t alu_rsp;
  isc_pkg::alu_op_e  bin_op, fold_op;

  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m2 = cnt_q - CW'(2);

  // Map command kinds onto the shared unit
  always_comb begin
    unique case (kind_q)
      isc_pkg::KIND_ADD:  bin_op = isc_pkg::ALU_ADD;
      isc_pkg::KIND_SUB:  bin_op = isc_pkg::ALU_SUB;
      isc_pkg::KIND_MULT: bin_op = isc_pkg::ALU_MUL;
      default:            bin_op = isc_pkg::ALU_DIV;
    endcase
    fold_op = (kind_q == isc_pkg::KIND_SUM) ? isc_pkg::ALU_ADD : isc_pkg::ALU_MUL;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    value_d  = value_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    top_d    = top_q;
    status_d = status_q;
    done_d   = 1'b0;
    res_d    = res_q;

    ram_we    = 1'b0;
    ram_waddr = cnt_m2[AW-1:0];
    ram_wdata = alu_rsp.result;
    ram_raddr = cnt_m1[AW-1:0];

    alu_req.start = 1'b0;
    alu_req.op    = bin_op;
    alu_req.a     = top_q;
    alu_req.b     = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d   = cmd_i.kind;
          value_d  = cmd_i.value;
          status_d = isc_pkg::ST_OK;
          state_d  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (kind_q)
          isc_pkg::KIND_PUSH: begin
            if (cnt_q == CW'(StackDepth)) begin
              status_d = isc_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AW-1:0];
              ram_wdata = value_q;
              cnt_d     = cnt_q + CW'(1);
            end
            state_d = S_FIN;
          end
          isc_pkg::KIND_POP: begin
            if (cnt_q == CW'(0)) begin
              // empty pop reports zero right away
              done_d                = 1'b1;
              res_d.result_value    = '0;
              res_d.status          = isc_pkg::ST_UNDER;
              res_d.occupancy       = 4'(cnt_q);
              state_d               = S_IDLE;
            end else begin
              cnt_d   = cnt_m1;
              state_d = S_POP_WAIT;
            end
          end
          isc_pkg::KIND_SUM: begin
            acc_d   = W'(0);
            idx_d   = CW'(0);
            state_d = S_FOLD_RD;
          end
          isc_pkg::KIND_PROD: begin
            acc_d   = W'(1);
            idx_d   = CW'(0);
            state_d = (cnt_q == CW'(0)) ? S_FIN : S_FOLD_RD;
          end
          default: begin
            // binary ops: read top first
            if (cnt_q < CW'(2)) begin
              status_d = isc_pkg::ST_UNDER;
              state_d  = S_FIN;
            end else begin
              state_d = S_RD_S;
            end
          end
        endcase
      end

      S_POP_WAIT: begin
        done_d             = 1'b1;
        res_d.result_value = ram_rdata;
        res_d.status       = status_q;
        res_d.occupancy    = 4'(cnt_q);
        state_d            = S_IDLE;
      end

      S_RD_S: begin
        top_d     = ram_rdata;
        ram_raddr = cnt_m2[AW-1:0];
        state_d   = S_OPERANDS;
      end

      S_OPERANDS: begin
        if (kind_q == isc_pkg::KIND_QUOT && ram_rdata == W'(0)) begin
          // divide by zero: drop second, keep top
          status_d  = isc_pkg::ST_DIVZ;
          ram_we    = 1'b1;
          ram_wdata = top_q;
          cnt_d     = cnt_m1;
          state_d   = S_FIN;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_BIN_WAIT;
        end
      end

      S_BIN_WAIT: begin
        if (alu_rsp.done) begin
          ram_we  = 1'b1;
          cnt_d   = cnt_m1;
          state_d = S_FIN;
        end
      end

      S_FOLD_RD: begin
        if (idx_q == cnt_q) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = acc_q;
          cnt_d     = CW'(1);
          state_d   = S_FIN;
        end else begin
          ram_raddr = idx_q[AW-1:0];
          state_d   = S_FOLD_OP;
        end
      end

      S_FOLD_OP: begin
        alu_req.start = 1'b1;
        alu_req.op    = fold_op;
        alu_req.a     = acc_q;
        idx_d         = idx_q + CW'(1);
        state_d       = S_FOLD_WAIT;
      end

      S_FOLD_WAIT: begin
        if (alu_rsp.done) begin
          acc_d   = alu_rsp.result;
          state_d = S_FOLD_RD;
        end
      end

      S_FIN: begin
        if (cnt_q == CW'(0)) begin
          done_d             = 1'b1;
          res_d.result_value = '0;
          res_d.status       = status_q;
          res_d.occupancy    = 4'(cnt_q);
          state_d            = S_IDLE;
        end else begin
          state_d = S_FIN_WAIT;
        end
      end

      S_FIN_WAIT: begin
        done_d             = 1'b1;
        res_d.result_value = ram_rdata;
        res_d.status       = status_q;
        res_d.occupancy    = 4'(cnt_q);
        state_d            = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    value_q  <= value_d;
    acc_q    <= acc_d;
    top_q    <= top_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  isc_ram #(
    .Width (W),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  isc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(StackDepth))
    else $error("stack count beyond depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer not busy");

  a_alu_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_BIN_WAIT || state_q == S_FOLD_WAIT))
    else $error("arithmetic unit finished outside a wait state");

endmodule

`default_nettype wire
